>>> rtl/core/rse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rse_pkg;

    // Default build sizes
    localparam int STACK_DEPTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // Saturation bounds of a stacked value
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_CHAR = 3'd1,
        ST_MISSING  = 3'd2,
        ST_LEFTOVER = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_DIV_ZERO = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CLS_START = 2'd0,
        CLS_TOKEN = 2'd1,
        CLS_SPACE = 2'd2
    } t_class;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_alu_op;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_DECODE,
        SEQ_READ_B,
        SEQ_READ_A,
        SEQ_WAIT,
        SEQ_FINISH,
        SEQ_EMIT
    } t_seq_state;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_LOOP,
        ALU_SIGN,
        ALU_SAT
    } t_alu_state;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value;
        t_status            status;
    } t_out;

    typedef struct packed {
        logic               start;
        t_alu_op            op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] result;
    } t_alu_rsp;

endpackage

`default_nettype wire

>>> rtl/core/rse_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module rse_alu #(
    parameter int FRACTION_BITS = rse_pkg::FRACTION_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rse_pkg::t_alu_req i_req,
    output rse_pkg::t_alu_rsp      o_rsp
);

    localparam int DIV_STEPS = 32 + FRACTION_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    rse_pkg::t_alu_state r_state, n_state;
    rse_pkg::t_alu_op    r_op, n_op;
    logic [31:0]         r_x, n_x;
    logic [31:0]         r_hi, n_hi;
    logic [63:0]         r_lo, n_lo;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_neg, n_neg;
    logic signed [64:0]  r_fix, n_fix;
    logic signed [31:0]  r_res, n_res;
    logic                r_done, n_done;

    logic [32:0]        add_p, add_q, add_sum;
    logic               add_sub;
    logic [31:0]        abs_a, abs_b;
    logic [63:0]        mag;
    logic signed [64:0] mag_s, signed_val;
    logic [33:0]        fix_top;

    // Shared 33-bit adder
    assign add_sum = add_p + (add_q ^ {33{add_sub}}) + 33'(add_sub);

    assign abs_a = i_req.a[31] ? 32'(-i_req.a) : 32'(i_req.a);
    assign abs_b = i_req.b[31] ? 32'(-i_req.b) : 32'(i_req.b);

    // Sign the finished magnitude
    assign mag        = (r_op == rse_pkg::OP_MUL) ? {r_hi, r_lo[31:0]} : r_lo;
    assign mag_s      = $signed({1'b0, mag});
    assign signed_val = r_neg ? -mag_s : mag_s;
    assign fix_top    = r_fix[64:31];

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            rse_pkg::ALU_IDLE: begin
                if (i_req.start) begin
                    if (i_req.op == rse_pkg::OP_ADD || i_req.op == rse_pkg::OP_SUB) begin
                        n_state = rse_pkg::ALU_SAT;
                    end else begin
                        n_state = rse_pkg::ALU_LOOP;
                    end
                end
            end
            rse_pkg::ALU_LOOP: begin
                if (r_cnt == '0) begin
                    n_state = rse_pkg::ALU_SIGN;
                end
            end
            rse_pkg::ALU_SIGN: n_state = rse_pkg::ALU_SAT;
            rse_pkg::ALU_SAT:  n_state = rse_pkg::ALU_IDLE;
            default:           n_state = rse_pkg::ALU_IDLE;
        endcase
    end

    // Drive the datapath
    always_comb begin
        n_op    = r_op;
        n_x     = r_x;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_fix   = r_fix;
        n_res   = r_res;
        n_done  = 1'b0;
        add_p   = '0;
        add_q   = '0;
        add_sub = 1'b0;
        case (r_state)
            rse_pkg::ALU_IDLE: begin
                add_p   = {i_req.a[31], i_req.a};
                add_q   = {i_req.b[31], i_req.b};
                add_sub = (i_req.op == rse_pkg::OP_SUB);
                if (i_req.start) begin
                    n_op  = i_req.op;
                    n_hi  = '0;
                    n_neg = i_req.a[31] ^ i_req.b[31];
                    n_fix = {{32{add_sum[32]}}, add_sum};
                    if (i_req.op == rse_pkg::OP_MUL) begin
                        n_x   = abs_a;
                        n_lo  = {32'd0, abs_b};
                        n_cnt = CNT_W'(31);
                    end else begin
                        n_x   = abs_b;
                        n_lo  = {abs_a, 32'd0};
                        n_cnt = CNT_W'(DIV_STEPS - 1);
                    end
                end
            end
            rse_pkg::ALU_LOOP: begin
                n_cnt = r_cnt - CNT_W'(1);
                if (r_op == rse_pkg::OP_MUL) begin
                    // Shift-add one multiplier bit
                    add_p = {1'b0, r_hi};
                    add_q = r_lo[0] ? {1'b0, r_x} : 33'd0;
                    n_hi  = add_sum[32:1];
                    n_lo  = {r_lo[63:32], add_sum[0], r_lo[31:1]};
                end else begin
                    // Restoring step: one quotient bit
                    add_p   = {r_hi, r_lo[63]};
                    add_q   = {1'b0, r_x};
                    add_sub = 1'b1;
                    n_hi    = add_sum[32] ? add_p[31:0] : add_sum[31:0];
                    n_lo    = {r_lo[62:0], ~add_sum[32]};
                end
            end
            rse_pkg::ALU_SIGN: begin
                if (r_op == rse_pkg::OP_MUL) begin
                    n_fix = signed_val >>> FRACTION_BITS;
                end else begin
                    n_fix = signed_val;
                end
            end
            rse_pkg::ALU_SAT: begin
                n_done = 1'b1;
                if (&fix_top || ~|fix_top) begin
                    n_res = r_fix[31:0];
                end else if (r_fix[64]) begin
                    n_res = rse_pkg::VAL_MIN;
                end else begin
                    n_res = rse_pkg::VAL_MAX;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rse_pkg::ALU_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_op  <= n_op;
        r_x   <= n_x;
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_fix <= n_fix;
        r_res <= n_res;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

`default_nettype wire

>>> rtl/core/rpn_stack_evaluator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Reverse-Polish evaluator taking one ASCII character per transfer: digits push
// d * 2^FRACTION_BITS, operators + - * / combine second-from-top with top, single
// spaces separate tokens, and the character flagged is_last yields one result
// (value in signed fixed point, saturated, with a status code; value is zero on
// any error). A character is worked on alone and o_in_ready stays low until it
// is done; * and / run in the shared iterative unit that does one multiplier
// bit or one quotient bit per cycle. The last character also loads the output
// register; a waiting result does not block the next character.

module rpn_stack_evaluator_top #(
    parameter int STACK_DEPTH   = rse_pkg::STACK_DEPTH_DEF,
    parameter int FRACTION_BITS = rse_pkg::FRACTION_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire rse_pkg::t_in i_in_data,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output rse_pkg::t_out     o_out_data
);

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int DIG_W  = 4 + FRACTION_BITS;
    localparam logic [LVL_W-1:0] LVL_DEPTH = LVL_W'(STACK_DEPTH);
    localparam logic [LVL_W-1:0] LVL_ONE   = LVL_W'(1);
    localparam logic [LVL_W-1:0] LVL_TWO   = LVL_W'(2);

    rse_pkg::t_seq_state r_state, n_state;
    logic [7:0]          r_char;
    logic                r_last;
    logic [LVL_W-1:0]    r_level, n_level;
    rse_pkg::t_class     r_class, n_class;
    rse_pkg::t_status    r_err, n_err;
    logic signed [31:0]  r_b, n_b;
    logic signed [31:0]  r_rd_data;
    logic signed [31:0]  r_stack [STACK_DEPTH];
    logic                r_out_valid, n_out_valid;
    rse_pkg::t_out       r_out, n_out;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic signed [31:0] wr_data;
    logic               is_space, is_digit, is_op, can_emit;
    logic [DIG_W-1:0]   dig_wide;
    logic signed [31:0] dig_val;
    rse_pkg::t_alu_op   char_op;
    rse_pkg::t_alu_req  alu_req;
    rse_pkg::t_alu_rsp  alu_rsp;

    // Classify the held character
    assign is_space = (r_char == rse_pkg::CH_SPACE);
    assign is_digit = r_char inside {[rse_pkg::CH_ZERO:rse_pkg::CH_NINE]};
    assign is_op    = r_char inside {rse_pkg::CH_PLUS, rse_pkg::CH_MINUS,
                                     rse_pkg::CH_STAR, rse_pkg::CH_SLASH};

    always_comb begin
        case (r_char)
            rse_pkg::CH_PLUS:  char_op = rse_pkg::OP_ADD;
            rse_pkg::CH_MINUS: char_op = rse_pkg::OP_SUB;
            rse_pkg::CH_STAR:  char_op = rse_pkg::OP_MUL;
            default:           char_op = rse_pkg::OP_DIV;
        endcase
    end

    // Scale a digit into fixed point, saturated
    assign dig_wide = DIG_W'(r_char[3:0]) << FRACTION_BITS;
    assign dig_val  = (64'(dig_wide) > 64'(rse_pkg::VAL_MAX)) ? rse_pkg::VAL_MAX
                                                               : 32'(dig_wide);

    assign can_emit = !r_out_valid || i_out_ready;

    rse_alu #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .o_rsp  (alu_rsp)
    );

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            rse_pkg::SEQ_IDLE: begin
                if (i_in_valid) begin
                    n_state = rse_pkg::SEQ_DECODE;
                end
            end
            rse_pkg::SEQ_DECODE: begin
                if (r_err == rse_pkg::ST_OK && !is_space && is_op
                        && r_class != rse_pkg::CLS_TOKEN && r_level >= LVL_TWO) begin
                    n_state = rse_pkg::SEQ_READ_B;
                end else begin
                    n_state = rse_pkg::SEQ_FINISH;
                end
            end
            rse_pkg::SEQ_READ_B: n_state = rse_pkg::SEQ_READ_A;
            rse_pkg::SEQ_READ_A: begin
                if (char_op == rse_pkg::OP_DIV && r_b == '0) begin
                    n_state = rse_pkg::SEQ_FINISH;
                end else begin
                    n_state = rse_pkg::SEQ_WAIT;
                end
            end
            rse_pkg::SEQ_WAIT: begin
                if (alu_rsp.done) begin
                    n_state = rse_pkg::SEQ_FINISH;
                end
            end
            rse_pkg::SEQ_FINISH: begin
                n_state = r_last ? rse_pkg::SEQ_EMIT : rse_pkg::SEQ_IDLE;
            end
            rse_pkg::SEQ_EMIT: begin
                if (can_emit) begin
                    n_state = rse_pkg::SEQ_IDLE;
                end
            end
            default: n_state = rse_pkg::SEQ_IDLE;
        endcase
    end

    // Drive stack, status and output updates
    always_comb begin
        n_level     = r_level;
        n_class     = r_class;
        n_err       = r_err;
        n_b         = r_b;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        wr_en       = 1'b0;
        wr_addr     = ADDR_W'(r_level);
        wr_data     = dig_val;
        rd_addr     = '0;
        alu_req     = '0;
        case (r_state)
            rse_pkg::SEQ_DECODE: begin
                if (r_level >= LVL_TWO) begin
                    rd_addr = ADDR_W'(r_level - LVL_ONE);
                end
                if (r_err != rse_pkg::ST_OK) begin
                    n_err = r_err;
                end else if (is_space) begin
                    if (r_class != rse_pkg::CLS_TOKEN || r_last) begin
                        n_err = rse_pkg::ST_BAD_CHAR;
                    end else begin
                        n_class = rse_pkg::CLS_SPACE;
                    end
                end else if (!is_digit && !is_op) begin
                    n_err = rse_pkg::ST_BAD_CHAR;
                end else if (r_class == rse_pkg::CLS_TOKEN) begin
                    n_err = rse_pkg::ST_BAD_CHAR;
                end else begin
                    n_class = rse_pkg::CLS_TOKEN;
                    if (is_digit) begin
                        if (r_level >= LVL_DEPTH) begin
                            n_err = rse_pkg::ST_OVERFLOW;
                        end else begin
                            wr_en   = 1'b1;
                            n_level = r_level + LVL_ONE;
                        end
                    end else if (r_level < LVL_TWO) begin
                        n_err = rse_pkg::ST_MISSING;
                    end
                end
            end
            rse_pkg::SEQ_READ_B: begin
                n_b     = r_rd_data;
                rd_addr = ADDR_W'(r_level - LVL_TWO);
            end
            rse_pkg::SEQ_READ_A: begin
                if (char_op == rse_pkg::OP_DIV && r_b == '0) begin
                    n_err = rse_pkg::ST_DIV_ZERO;
                end else begin
                    alu_req.start = 1'b1;
                    alu_req.op    = char_op;
                    alu_req.a     = r_rd_data;
                    alu_req.b     = r_b;
                end
            end
            rse_pkg::SEQ_WAIT: begin
                wr_addr = ADDR_W'(r_level - LVL_TWO);
                wr_data = alu_rsp.result;
                if (alu_rsp.done) begin
                    wr_en   = 1'b1;
                    n_level = r_level - LVL_ONE;
                end
            end
            rse_pkg::SEQ_EMIT: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    if (r_err != rse_pkg::ST_OK) begin
                        n_out.status = r_err;
                        n_out.value  = '0;
                    end else if (r_level != LVL_ONE) begin
                        n_out.status = rse_pkg::ST_LEFTOVER;
                        n_out.value  = '0;
                    end else begin
                        n_out.status = rse_pkg::ST_OK;
                        n_out.value  = r_rd_data;
                    end
                    n_level = '0;
                    n_class = rse_pkg::CLS_START;
                    n_err   = rse_pkg::ST_OK;
                end
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    // Hold the operand stack
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[wr_addr] <= wr_data;
        end
        r_rd_data <= r_stack[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rse_pkg::SEQ_IDLE;
            r_level     <= '0;
            r_class     <= rse_pkg::CLS_START;
            r_err       <= rse_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_level     <= n_level;
            r_class     <= n_class;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        if (r_state == rse_pkg::SEQ_IDLE && i_in_valid) begin
            r_char <= i_in_data.char_code;
            r_last <= i_in_data.is_last;
        end
        r_b   <= n_b;
        r_out <= n_out;
    end

    assign o_in_ready  = (r_state == rse_pkg::SEQ_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> rtl/core/rse_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rse_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire rse_pkg::t_in  i_in_data,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire rse_pkg::t_out o_out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // A waiting character holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input changed while waiting");

    // An error result carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != rse_pkg::ST_OK)
            |-> (o_out_data.value == '0))
        else $error("error result with nonzero value");

    // One character at a time: ready drops after each transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after input transfer");

    // Reset drops the result
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind rpn_stack_evaluator_top rse_checker u_rse_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

`default_nettype wire
